/* hdl/kcst_pkg.sv */
package kcst_pkg;

  localparam int unsigned LocusAw = 12;
  localparam int unsigned IndAw   = 8;
  localparam int unsigned DivW    = 52;

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_RD_LOC  = 2'd1,
    OP_RD_IND  = 2'd2,
    OP_SUMMARY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_LOCUS   = 2'd0,
    KIND_IND     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_HIGH = 2'd1,
    REG_NIND = 2'd2
  } reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_REC, ST_ENT, ST_ENT_DIV,
    ST_L_RD, ST_L_EVAL, ST_L_DIV,
    ST_I_RD, ST_I_EVAL, ST_I_DIV,
    ST_F_LOC, ST_F_LOC_DIV, ST_F_IND, ST_F_IND_DIV
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [IndAw-1:0]    ind;
    logic [LocusAw-1:0]  loc;
    logic [15:0]         depth;
  } cmd_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [15:0] cnt;
    logic [15:0] mn;
    logic [15:0] mx;
    logic [15:0] olo;
    logic [15:0] ohi;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] record_count;
    logic [31:0] depth_total;
    logic [23:0] average_q8;
    logic [23:0] average_ind_q8;
    logic [15:0] min_value;
    logic [15:0] max_value;
    logic [15:0] count_low;
    logic [15:0] count_high;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } back_status_t;

  localparam entry_t EntryClear = '{sum: '0, cnt: '0, mn: 16'hFFFF, mx: '0, olo: '0, ohi: '0};

endpackage

/* hdl/kcst_front.sv */
module kcst_front import kcst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] ind_i,
  input  logic [11:0] loc_i,
  input  logic [15:0] depth_i,
  output logic       head_valid_o,
  output cmd_t       head_o,
  input  logic       pop_i,
  output logic [1:0] count_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd;

  always_comb begin
    cmd.op    = op_e'(mode_i);
    cmd.ind   = ind_i;
    cmd.loc   = loc_i;
    cmd.depth = depth_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rptr_q];
  assign count_o      = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= cmd;
  end

endmodule

/* hdl/kcst_div.sv */
module kcst_div import kcst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [15:0]     divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic            busy_q, done_q;
  logic [5:0]      cnt_q;
  logic [15:0]     rem_q, rem_d, div_q;
  logic [DivW-1:0] quo_q, quo_d;
  logic [16:0]     rem_sh;
  logic            qbit;

  // one quotient bit per cycle while busy, restoring
  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    qbit   = (rem_sh >= {1'b0, div_q});
    rem_d  = qbit ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
    quo_d  = {quo_q[DivW-2:0], qbit};
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DivW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule

/* hdl/kcst_back.sv */
module kcst_back import kcst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         head_valid_i,
  input  cmd_t         head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output result_t      out_o,
  output back_status_t status_o
);

  state_e state_q, state_d;

  logic [15:0] low_q, high_q;
  logic [8:0]  nind_q, nind_eff;

  entry_t loc_mem [1 << LocusAw];
  entry_t ind_mem [1 << IndAw];
  entry_t loc_rd_q, ind_rd_q;
  logic [LocusAw-1:0] loc_addr;
  logic [IndAw-1:0]   ind_addr;
  logic               mem_we;
  entry_t             loc_wr, ind_wr;

  cmd_t   cmd_q;
  entry_t ent_q;
  logic [LocusAw-1:0] idx_q, clr_q;
  logic [LocusAw-1:0] high_loc_q;
  logic               seen_q;

  logic [12:0] with_q, nlo_q, nhi_q;
  logic [15:0] mn_q, mx_q;
  logic [43:0] asum_q;
  logic [39:0] isum_q;
  logic [23:0] sloc_q;

  result_t res_q;
  logic    out_valid_q;

  logic            div_start, div_done;
  logic [DivW-1:0] div_dividend, div_quot;
  logic [15:0]     div_divisor;

  logic   loc_acc, ind_acc, load_out;
  entry_t acc_ent;
  logic [31:0] acc_a;
  result_t res_d;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic entry_t entry_add(input entry_t e, input logic [15:0] d,
                                       input logic [15:0] lo, input logic [15:0] hi);
    entry_t     r;
    logic [32:0] s;
    r = e;
    s = {1'b0, e.sum} + {17'b0, d};
    r.sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
    r.cnt = inc16(e.cnt);
    if (d >= lo) r.olo = inc16(e.olo);
    if (d >= hi) r.ohi = inc16(e.ohi);
    if (d < e.mn) r.mn = d;
    if (d > e.mx) r.mx = d;
    return r;
  endfunction

  function automatic logic [23:0] avg_q8(input logic [31:0] q);
    return (q[31:16] != 16'd0) ? 24'hFF_FFFF : {q[15:0], 8'd0};
  endfunction

  assign nind_eff = (nind_q > 9'd256) ? 9'd256 : nind_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (head_valid_i && !out_valid_q) begin
          unique case (head_i.op)
            OP_RECORD:            state_d = ST_REC;
            OP_RD_LOC, OP_RD_IND: state_d = ST_ENT;
            OP_SUMMARY: begin
              if (seen_q) state_d = ST_L_RD;
              else if (nind_eff != 9'd0) state_d = ST_I_RD;
              else state_d = ST_F_LOC;
            end
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_REC:     state_d = ST_IDLE;
      ST_ENT: begin
        if ((cmd_q.op == OP_RD_LOC ? loc_rd_q.cnt : ind_rd_q.cnt) == 16'd0) state_d = ST_IDLE;
        else state_d = ST_ENT_DIV;
      end
      ST_ENT_DIV: if (div_done) state_d = ST_IDLE;
      ST_L_RD:    state_d = ST_L_EVAL;
      ST_L_EVAL, ST_L_DIV: begin
        if ((state_q == ST_L_EVAL && loc_rd_q.cnt != 16'd0)) state_d = ST_L_DIV;
        else if (state_q == ST_L_EVAL || div_done) begin
          if (idx_q != high_loc_q) state_d = ST_L_RD;
          else if (nind_eff != 9'd0) state_d = ST_I_RD;
          else state_d = ST_F_LOC;
        end
      end
      ST_I_RD:    state_d = ST_I_EVAL;
      ST_I_EVAL, ST_I_DIV: begin
        if ((state_q == ST_I_EVAL && ind_rd_q.cnt != 16'd0)) state_d = ST_I_DIV;
        else if (state_q == ST_I_EVAL || div_done) begin
          if ({1'b0, idx_q[IndAw-1:0]} != 9'(nind_eff - 9'd1)) state_d = ST_I_RD;
          else state_d = ST_F_LOC;
        end
      end
      ST_F_LOC:     state_d = (with_q == 13'd0) ? ST_F_IND : ST_F_LOC_DIV;
      ST_F_LOC_DIV: if (div_done) state_d = ST_F_IND;
      ST_F_IND:     state_d = (nind_eff == 9'd0) ? ST_IDLE : ST_F_IND_DIV;
      ST_F_IND_DIV: if (div_done) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    loc_addr     = head_i.loc;
    ind_addr     = head_i.ind;
    loc_wr       = EntryClear;
    ind_wr       = EntryClear;
    div_start    = 1'b0;
    div_dividend = {20'd0, ind_rd_q.sum};
    div_divisor  = ind_rd_q.cnt;
    loc_acc      = 1'b0;
    ind_acc      = 1'b0;
    load_out     = 1'b0;
    acc_ent      = loc_rd_q;
    acc_a        = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        loc_addr = clr_q;
        ind_addr = clr_q[IndAw-1:0];
      end
      ST_IDLE: pop_o = head_valid_i && !out_valid_q;
      ST_REC: begin
        mem_we   = 1'b1;
        loc_addr = cmd_q.loc;
        ind_addr = cmd_q.ind;
        loc_wr   = entry_add(loc_rd_q, cmd_q.depth, low_q, high_q);
        ind_wr   = entry_add(ind_rd_q, cmd_q.depth, low_q, high_q);
      end
      ST_ENT: begin
        if (cmd_q.op == OP_RD_LOC) begin
          div_dividend = {20'd0, loc_rd_q.sum};
          div_divisor  = loc_rd_q.cnt;
        end
        div_start = (div_divisor != 16'd0);
        load_out  = !div_start;
      end
      ST_ENT_DIV: load_out = div_done;
      ST_L_RD: loc_addr = idx_q;
      ST_L_EVAL: begin
        div_dividend = {20'd0, loc_rd_q.sum};
        div_divisor  = loc_rd_q.cnt;
        div_start    = (loc_rd_q.cnt != 16'd0);
        loc_acc      = !div_start;
      end
      ST_L_DIV: begin
        acc_ent = ent_q;
        acc_a   = div_quot[31:0];
        loc_acc = div_done;
      end
      ST_I_RD: ind_addr = idx_q[IndAw-1:0];
      ST_I_EVAL: begin
        div_start = (ind_rd_q.cnt != 16'd0);
        ind_acc   = !div_start;
      end
      ST_I_DIV: begin
        acc_a   = div_quot[31:0];
        ind_acc = div_done;
      end
      ST_F_LOC: begin
        div_dividend = {asum_q, 8'd0};
        div_divisor  = {3'd0, with_q};
        div_start    = (with_q != 13'd0);
      end
      ST_F_IND: begin
        div_dividend = {4'd0, isum_q, 8'd0};
        div_divisor  = {7'd0, nind_eff};
        div_start    = (nind_eff != 9'd0);
        load_out     = !div_start;
      end
      ST_F_IND_DIV: load_out = div_done;
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    entry_t e;
    e     = (cmd_q.op == OP_RD_LOC) ? loc_rd_q : ind_rd_q;
    if (state_q == ST_ENT_DIV) e = ent_q;
    res_d = '0;
    if (cmd_q.op == OP_SUMMARY) begin
      res_d.kind           = KIND_SUMMARY;
      res_d.record_count   = {3'd0, with_q};
      res_d.average_q8     = sloc_q;
      res_d.average_ind_q8 = (state_q == ST_F_IND_DIV)
                             ? ((div_quot[DivW-1:24] != '0) ? 24'hFF_FFFF : div_quot[23:0])
                             : 24'd0;
      res_d.min_value      = mn_q;
      res_d.max_value      = mx_q;
      res_d.count_low      = {3'd0, nlo_q};
      res_d.count_high     = {3'd0, nhi_q};
    end else begin
      res_d.kind         = (cmd_q.op == OP_RD_LOC) ? KIND_LOCUS : KIND_IND;
      res_d.record_count = e.cnt;
      res_d.depth_total  = e.sum;
      res_d.average_q8   = (state_q == ST_ENT_DIV) ? avg_q8(div_quot[31:0]) : 24'd0;
      res_d.min_value    = (e.cnt == 16'd0) ? 16'd0 : e.mn;
      res_d.max_value    = e.mx;
      res_d.count_low    = e.olo;
      res_d.count_high   = e.ohi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      loc_mem[loc_addr] <= loc_wr;
      ind_mem[ind_addr] <= ind_wr;
    end
    loc_rd_q <= loc_mem[loc_addr];
    ind_rd_q <= ind_mem[ind_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      low_q       <= 16'd5;
      high_q      <= 16'd10;
      nind_q      <= 9'd0;
      high_loc_q  <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOW:  low_q  <= cfg_data_i;
          REG_HIGH: high_q <= cfg_data_i;
          REG_NIND: nind_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (state_q == ST_REC) begin
        if (!seen_q || cmd_q.loc > high_loc_q) high_loc_q <= cmd_q.loc;
        seen_q <= 1'b1;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // walk accumulators and datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= head_i;
      idx_q  <= '0;
      with_q <= '0;
      nlo_q  <= '0;
      nhi_q  <= '0;
      mn_q   <= seen_q ? 16'hFFFF : 16'd0;
      mx_q   <= '0;
      asum_q <= '0;
      isum_q <= '0;
      sloc_q <= '0;
    end
    if (state_q == ST_ENT) ent_q <= (cmd_q.op == OP_RD_LOC) ? loc_rd_q : ind_rd_q;
    if (state_q == ST_L_EVAL) ent_q <= loc_rd_q;
    if (loc_acc) begin
      if (acc_ent.cnt != 16'd0) with_q <= with_q + 13'd1;
      if (acc_ent.cnt < mn_q) mn_q <= acc_ent.cnt;
      if (acc_ent.cnt > mx_q) mx_q <= acc_ent.cnt;
      if (acc_a >= {16'd0, low_q})  nlo_q <= nlo_q + 13'd1;
      if (acc_a >= {16'd0, high_q}) nhi_q <= nhi_q + 13'd1;
      asum_q <= asum_q + {12'd0, acc_a};
      idx_q  <= (idx_q == high_loc_q) ? '0 : idx_q + 1'b1;
    end
    if (ind_acc) begin
      isum_q <= isum_q + {8'd0, acc_a};
      idx_q  <= idx_q + 1'b1;
    end
    if (state_q == ST_F_LOC_DIV && div_done)
      sloc_q <= (div_quot[DivW-1:24] != '0) ? 24'hFF_FFFF : div_quot[23:0];
    if (load_out) res_q <= res_d;
  end

  kcst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o       = out_valid_q;
  assign out_o             = res_q;
  assign status_o.clearing = (state_q == ST_CLEAR);
  assign status_o.idle     = (state_q == ST_IDLE);

endmodule

/* hdl/keyed_coverage_stats_table_unit.sv */
// channel   | dir | tdata fields (low bit up)                               | tuser
// s_axis    | in  | individual 8, locus 12, depth 16, pad 4                 | mode 2
// m_axis    | out | record_count, depth_total, average_q8, average_ind_q8,  | kind 2
//           |     | min_value, max_value, count_low, count_high             |
// cfg       | in  | cfg_index_i selects register, cfg_data_i 16 bits        |
// after reset a clearing pass sweeps every entry of both tables; inputs queue meanwhile
// record: table read, then write back, as each table has a single port
// entry read: table read, then a division on the shared 52-step divider if the count is nonzero
// summary: walks each locus up to the highest recorded one, then each individual,
// dividing for each one with data; then runs each of the two final divisions that has a nonzero divisor
// a 2-deep queue decouples input from the back end; results wait in an output register
module keyed_coverage_stats_table_unit import kcst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // individual, locus, depth, zero pad
  input  logic [1:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // record_count, depth_total, average_q8,
                                       // average_ind_q8, min_value, max_value,
                                       // count_low, count_high
  output logic [1:0]   m_axis_tuser,   // kind
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  logic         head_valid, pop;
  cmd_t         head;
  logic [1:0]   q_count;
  result_t      res;
  back_status_t status;

  // front: queue of decoded commands
  kcst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .mode_i       (s_axis_tuser),
    .ind_i        (s_axis_tdata[7:0]),
    .loc_i        (s_axis_tdata[19:8]),
    .depth_i      (s_axis_tdata[35:20]),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop),
    .count_o      (q_count)
  );

  // back: tables, walk sequencer, divider, result register
  kcst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res),
    .status_o     (status)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {res.count_high, res.count_low, res.max_value, res.min_value,
                         res.average_ind_q8, res.average_q8, res.depth_total,
                         res.record_count};

  // nothing leaves the queue during the clearing pass
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !pop) else $error("pop during clear");

  // pops only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != 2'd0)) else $error("pop from empty queue");

  // summary kind never shows a depth total
  a_summary_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_SUMMARY) |-> (res.depth_total == 32'd0))
    else $error("summary with depth total");

  // a pop is only taken with the back end idle and the result slot free
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (status.idle && !m_axis_tvalid)) else $error("pop while busy");

endmodule
